// File: rtl/rti_pkg.sv
// Shared types, constants and helpers of the ray/triangle intersection block.
package rti_pkg;

	localparam int CoordW = 32;
	localparam int FracW  = 16;
	localparam int AccW   = 64;
	localparam int DistW  = 31;
	localparam int CfgIdxW = 3;

	localparam logic signed [AccW-1:0] SMax = {1'b0, {(AccW-1){1'b1}}};
	localparam logic [DistW-1:0] DistMax = {DistW{1'b1}};

	typedef logic signed [CoordW-1:0] coord_t;
	typedef logic signed [AccW-1:0]   acc_t;

	typedef struct packed {
		coord_t z;
		coord_t y;
		coord_t x;
	} vec3_t;

	typedef struct packed {
		vec3_t e1;
		vec3_t e2;
		vec3_t s;
		logic  last;
	} tri_t;

	typedef struct packed {
		vec3_t        org;
		vec3_t        dir;
		logic [31:0]  thr;
	} cfg_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_ORG_X = 3'd0,
		REG_ORG_Y = 3'd1,
		REG_ORG_Z = 3'd2,
		REG_DIR_X = 3'd3,
		REG_DIR_Y = 3'd4,
		REG_DIR_Z = 3'd5,
		REG_THR   = 3'd6
	} cfg_reg_t;

	typedef enum logic [2:0] {
		PH_H, PH_Q, PH_DET, PH_U, PH_V, PH_T
	} phase_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_MUL, ST_ACC, ST_SIGN, ST_CHECK, ST_DIV, ST_FIN
	} state_t;

	function automatic coord_t comp_sel(vec3_t v, logic [1:0] i);
		coord_t r;
		unique case (i)
			2'd0:    r = v.x;
			2'd1:    r = v.y;
			default: r = v.z;
		endcase
		return r;
	endfunction

	function automatic logic [1:0] next3(logic [1:0] i);
		return (i == 2'd2) ? 2'd0 : i + 2'd1;
	endfunction

	function automatic coord_t sub_sat(coord_t a, coord_t b);
		logic signed [CoordW:0] d;
		d = {a[CoordW-1], a} - {b[CoordW-1], b};
		if (d[CoordW] != d[CoordW-1])
			return d[CoordW] ? {1'b1, {(CoordW-1){1'b0}}} : {1'b0, {(CoordW-1){1'b1}}};
		return d[CoordW-1:0];
	endfunction

	function automatic acc_t add_sat(acc_t a, acc_t b);
		logic signed [AccW:0] s;
		s = {a[AccW-1], a} + {b[AccW-1], b};
		if (!s[AccW] && s[AccW-1])
			return SMax;
		if (s[AccW] && (!s[AccW-1] || s[AccW-2:0] == '0))
			return -SMax;
		return s[AccW-1:0];
	endfunction

	function automatic coord_t shift_sat(acc_t a);
		acc_t sh;
		sh = a >>> FracW;
		if (sh[AccW-1:CoordW-1] == '0 || sh[AccW-1:CoordW-1] == '1)
			return sh[CoordW-1:0];
		return sh[AccW-1] ? {1'b1, {(CoordW-1){1'b0}}} : {1'b0, {(CoordW-1){1'b1}}};
	endfunction

endpackage

// File: rtl/rti_front.sv
// Front end: edge and offset vectors per triangle, into a two-entry queue.
module rti_front import rti_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  vec3_t  v0,
	input  vec3_t  v1,
	input  vec3_t  v2,
	input  logic   in_last,
	input  vec3_t  org,
	output logic   q_valid,
	output tri_t   q_head,
	input  logic   q_pop
);

	tri_t       mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	tri_t       entry;
	logic       push;

	always_comb begin
		entry.e1.x = sub_sat(v1.x, v0.x);
		entry.e1.y = sub_sat(v1.y, v0.y);
		entry.e1.z = sub_sat(v1.z, v0.z);
		entry.e2.x = sub_sat(v2.x, v0.x);
		entry.e2.y = sub_sat(v2.y, v0.y);
		entry.e2.z = sub_sat(v2.z, v0.z);
		entry.s.x  = sub_sat(org.x, v0.x);
		entry.s.y  = sub_sat(org.y, v0.y);
		entry.s.z  = sub_sat(org.z, v0.z);
		entry.last = in_last;
	end

	assign in_ready = (cnt_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_head   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= ~wr_q;
			if (q_pop)
				rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

endmodule

// File: rtl/rti_back.sv
// Back end: shared multiplier sequence, threshold and range checks, divider, result register.
module rti_back import rti_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              q_valid,
	input  tri_t              q_head,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              out_hit,
	output logic [DistW-1:0]  out_dist,
	output logic              out_any,
	output logic [DistW-1:0]  out_best,
	output logic              out_last
);

	state_t           state_q, state_d;
	phase_t           phase_q;
	logic [1:0]       comp_q;
	logic             term_q;
	tri_t             work_q;
	vec3_t            h_q, qv_q;
	acc_t             acc_q, prod_q, acc_nx;
	acc_t             det_q, un_q, vn_q, tn_q;
	logic [AccW-1:0]  rem_q;
	logic [FracW+14:0] nlow_q;
	logic [4:0]       cnt_q;
	logic [DistW-1:0] dist_q;
	logic [DistW-1:0] best_q;
	logic             seen_q;
	coord_t           op_a, op_b;
	logic [1:0]       i1, i2;
	vec3_t            va, vb;
	logic             is_cross, last_step, pass, big;
	logic [AccW:0]    rem_w;
	logic             rem_ge;
	logic             slot_free, hit;
	logic [DistW-1:0] best_nx;

	assign i1 = next3(comp_q);
	assign i2 = next3(i1);
	assign is_cross = (phase_q == PH_H) || (phase_q == PH_Q);

	always_comb begin
		unique case (phase_q)
			PH_H:    begin va = cfg.dir;  vb = work_q.e2; end
			PH_Q:    begin va = work_q.s; vb = work_q.e1; end
			PH_DET:  begin va = work_q.e1; vb = h_q; end
			PH_U:    begin va = work_q.s; vb = h_q; end
			PH_V:    begin va = cfg.dir;  vb = qv_q; end
			default: begin va = work_q.e2; vb = qv_q; end
		endcase
		if (is_cross) begin
			op_a = comp_sel(va, term_q ? i2 : i1);
			op_b = comp_sel(vb, term_q ? i1 : i2);
		end else begin
			op_a = comp_sel(va, comp_q);
			op_b = comp_sel(vb, comp_q);
		end
	end

	assign acc_nx = add_sat(acc_q, (is_cross && term_q) ? -prod_q : prod_q);
	assign last_step = (phase_q == PH_T) && (comp_q == 2'd2);

	assign pass = (det_q != '0) && (det_q >= $signed({32'b0, cfg.thr})) &&
		!un_q[AccW-1] && (un_q <= det_q) && !vn_q[AccW-1] &&
		(($unsigned(un_q) + $unsigned(vn_q)) <= $unsigned(det_q)) &&
		!tn_q[AccW-1] && (tn_q != '0);
	assign big = {15'b0, tn_q} >= {det_q, 15'b0};

	assign rem_w  = {rem_q, nlow_q[FracW+14]};
	assign rem_ge = rem_w >= {1'b0, det_q};

	assign slot_free = !out_valid || out_ready;
	assign hit       = (dist_q != '0);
	assign best_nx   = (hit && dist_q < best_q) ? dist_q : best_q;

	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					q_pop   = 1'b1;
					state_d = ST_MUL;
				end
			end
			ST_MUL:   state_d = ST_ACC;
			ST_ACC:   state_d = last_step ? ST_SIGN : ST_MUL;
			ST_SIGN:  state_d = ST_CHECK;
			ST_CHECK: state_d = (pass && !big) ? ST_DIV : ST_FIN;
			ST_DIV:   state_d = (cnt_q == '0) ? ST_FIN : ST_DIV;
			ST_FIN:   state_d = slot_free ? ST_IDLE : ST_FIN;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			phase_q   <= PH_H;
			comp_q    <= 2'd0;
			term_q    <= 1'b0;
			seen_q    <= 1'b0;
			best_q    <= DistMax;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_FIN && slot_free)
				out_valid <= 1'b1;
			else if (out_ready)
				out_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					phase_q <= PH_H;
					comp_q  <= 2'd0;
					term_q  <= 1'b0;
				end
				ST_ACC: begin
					if (is_cross) begin
						term_q <= ~term_q;
						if (term_q) begin
							comp_q <= (comp_q == 2'd2) ? 2'd0 : comp_q + 2'd1;
							if (comp_q == 2'd2)
								phase_q <= phase_t'(phase_q + 3'd1);
						end
					end else begin
						comp_q <= (comp_q == 2'd2) ? 2'd0 : comp_q + 2'd1;
						if (comp_q == 2'd2 && !last_step)
							phase_q <= phase_t'(phase_q + 3'd1);
					end
				end
				ST_FIN: begin
					if (slot_free) begin
						seen_q    <= work_q.last ? 1'b0 : (seen_q | hit);
						best_q    <= work_q.last ? DistMax : best_nx;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				work_q <= q_head;
				acc_q  <= '0;
			end
			ST_MUL: prod_q <= op_a * op_b;
			ST_ACC: begin
				if (is_cross) begin
					if (term_q) begin
						acc_q <= '0;
						unique case ({phase_q == PH_Q, comp_q})
							3'b000:  h_q.x  <= shift_sat(acc_nx);
							3'b001:  h_q.y  <= shift_sat(acc_nx);
							3'b010:  h_q.z  <= shift_sat(acc_nx);
							3'b100:  qv_q.x <= shift_sat(acc_nx);
							3'b101:  qv_q.y <= shift_sat(acc_nx);
							default: qv_q.z <= shift_sat(acc_nx);
						endcase
					end else begin
						acc_q <= acc_nx;
					end
				end else if (comp_q != 2'd2) begin
					acc_q <= acc_nx;
				end else begin
					acc_q <= '0;
					unique case (phase_q)
						PH_DET:  det_q <= acc_nx;
						PH_U:    un_q  <= acc_nx;
						PH_V:    vn_q  <= acc_nx;
						default: tn_q  <= acc_nx;
					endcase
				end
			end
			ST_SIGN: begin
				if (det_q[AccW-1]) begin
					det_q <= -det_q;
					un_q  <= -un_q;
					vn_q  <= -vn_q;
					tn_q  <= -tn_q;
				end
			end
			ST_CHECK: begin
				dist_q <= (pass && big) ? DistMax : '0;
				rem_q  <= {15'b0, tn_q[AccW-1:15]};
				nlow_q <= {tn_q[14:0], {FracW{1'b0}}};
				cnt_q  <= 5'(DistW - 1);
			end
			ST_DIV: begin
				rem_q  <= rem_ge ? AccW'(rem_w - {1'b0, det_q}) : rem_w[AccW-1:0];
				nlow_q <= {nlow_q[FracW+13:0], 1'b0};
				dist_q <= {dist_q[DistW-2:0], rem_ge};
				cnt_q  <= cnt_q - 5'd1;
			end
			ST_FIN: begin
				if (slot_free) begin
					out_hit  <= hit;
					out_dist <= dist_q;
					out_any  <= seen_q | hit;
					out_best <= best_nx;
					out_last <= work_q.last;
				end
			end
			default: ;
		endcase
	end

endmodule

// File: rtl/ray_triangle_intersect.sv
// Top level of the ray/triangle intersection block: ports, ray registers, front and back ends.
// Each triangle is tested by one shared 32x32 multiplier over 24 multiply/accumulate steps
// (each an ST_MUL then an ST_ACC state), then a restoring divider producing one distance bit
// per cycle; a rejected or saturated triangle skips the divider, and an output stall holds
// the result. A two-entry queue behind the input lets the next triangles be taken while one
// is in work. Ray registers are written through the cfg port (index 0..2 origin, 3..5
// direction, 6 determinant threshold) and take effect on the next triangle; write them only
// while the block is idle.
module ray_triangle_intersect import rti_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [287:0]        s_axis_tdata,  // vert0_x,y,z, vert1_x,y,z, vert2_x,y,z
	input  logic                s_axis_tlast,  // last_triangle
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [63:0]         m_axis_tdata,  // tri_hit, tri_distance, any_hit, closest_distance
	output logic                m_axis_tlast,  // group_done
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [31:0]         cfg_data
);

	cfg_t             cfg_q;
	logic             q_valid, q_pop;
	tri_t             q_head;
	logic             o_hit, o_any;
	logic [DistW-1:0] o_dist, o_best;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.org <= '0;
			cfg_q.dir <= '{z: 32'shFFFF0000, y: '0, x: '0};
			cfg_q.thr <= 32'd1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_ORG_X: cfg_q.org.x <= cfg_data;
				REG_ORG_Y: cfg_q.org.y <= cfg_data;
				REG_ORG_Z: cfg_q.org.z <= cfg_data;
				REG_DIR_X: cfg_q.dir.x <= cfg_data;
				REG_DIR_Y: cfg_q.dir.y <= cfg_data;
				REG_DIR_Z: cfg_q.dir.z <= cfg_data;
				REG_THR:   cfg_q.thr   <= cfg_data;
				default: ;
			endcase
		end
	end

	rti_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.v0       ({s_axis_tdata[95:64],   s_axis_tdata[63:32],   s_axis_tdata[31:0]}),
		.v1       ({s_axis_tdata[191:160], s_axis_tdata[159:128], s_axis_tdata[127:96]}),
		.v2       ({s_axis_tdata[287:256], s_axis_tdata[255:224], s_axis_tdata[223:192]}),
		.in_last  (s_axis_tlast),
		.org      (cfg_q.org),
		.q_valid  (q_valid),
		.q_head   (q_head),
		.q_pop    (q_pop)
	);

	rti_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_hit   (o_hit),
		.out_dist  (o_dist),
		.out_any   (o_any),
		.out_best  (o_best),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = {o_best, o_any, o_dist, o_hit};

	a_hit_dist: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && o_hit |-> o_dist != '0)
		else $error("hit reported at zero distance");
	a_hit_any: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && o_hit |-> o_any && o_best <= o_dist)
		else $error("running state misses this hit");
	a_none_best: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !o_any |-> o_best == DistMax)
		else $error("closest distance set without a hit");
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !o_hit |-> o_dist == '0)
		else $error("miss with nonzero distance");

endmodule
